// ----- design/lfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types, constants and the CRC-32 byte step for the log record
// frame checker.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int unsigned LEN_W       = 27;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned INTACT_W    = 40;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned OFFSET_BITS_DEF = 40;

    localparam logic [31:0]      CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0]      CRC_ONES     = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] LIMIT_RESET  = LEN_W'(64 << 20);
    localparam int unsigned      HEADER_BYTES = 8;
    localparam int unsigned      MARK_BYTES   = 4;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result kinds
    localparam logic EV_RECORD = 1'b0;
    localparam logic EV_STOP   = 1'b1;

    // stop causes
    localparam logic [2:0] CAUSE_NONE   = 3'd0;
    localparam logic [2:0] CAUSE_CLEAN  = 3'd1;
    localparam logic [2:0] CAUSE_TRUNC  = 3'd2;
    localparam logic [2:0] CAUSE_LENGTH = 3'd3;
    localparam logic [2:0] CAUSE_MARK   = 3'd4;
    localparam logic [2:0] CAUSE_CRC    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARK       = 1'b1;

    typedef enum logic [3:0] {
        PH_LEN     = 4'b0001,
        PH_CRC     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_MARK    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       opcode;
        logic [7:0] log_byte;
    } t_item;

    typedef struct packed {
        logic                event_res;
        logic [2:0]          stop_cause;
        logic [LEN_W-1:0]    record_len;
        logic [WORD_W-1:0]   record_count;
        logic [INTACT_W-1:0] intact_end;
    } t_result;

    typedef struct packed {
        logic [LEN_W-1:0]  max_record_len;
        logic [WORD_W-1:0] end_mark;
    } t_cfg;

    // one byte through the reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/lfc_if.sv -----
// ----------------------------------------------------------------------------
// lfc_if
// Valid/ready channels of the frame checker: log bytes in, results out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface lfc_item_if import lfc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] log_byte;

    modport source (output valid, output opcode, output log_byte, input ready);
    modport sink   (input valid, input opcode, input log_byte, output ready);
endinterface

interface lfc_res_if import lfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                event_res;
    logic [2:0]          stop_cause;
    logic [LEN_W-1:0]    record_len;
    logic [WORD_W-1:0]   record_count;
    logic [INTACT_W-1:0] intact_end;

    modport source (output valid, output event_res, output stop_cause, output record_len,
                    output record_count, output intact_end, input ready);
    modport sink   (input valid, input event_res, input stop_cause, input record_len,
                    input record_count, input intact_end, output ready);
endinterface

interface lfc_cfg_if import lfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/lfc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lfc_cfg_regs
// Configuration registers: record length limit and expected end mark.
// ----------------------------------------------------------------------------
module lfc_cfg_regs import lfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfc_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    logic [LEN_W-1:0]  r_max_len;
    logic [WORD_W-1:0] r_end_mark;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= LIMIT_RESET;
            r_end_mark <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_RECORD_LEN: r_max_len  <= i_cfg.data[LEN_W-1:0];
                CFG_END_MARK:       r_end_mark <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg.max_record_len = r_max_len;
    assign o_cfg.end_mark       = r_end_mark;

endmodule

// ----- design/lfc_in_stage.sv -----
// ----------------------------------------------------------------------------
// lfc_in_stage
// Input register for log beats; refills whenever the scan stage takes the
// held beat.
// ----------------------------------------------------------------------------
module lfc_in_stage import lfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lfc_item_if.sink i_log,
    input  logic     i_take,
    output logic     o_valid,
    output t_item    o_item
);

    logic  r_valid;
    t_item r_item;

    assign i_log.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_log.ready) begin
            r_valid <= i_log.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_log.ready) begin
            r_item.opcode   <= i_log.opcode;
            r_item.log_byte <= i_log.log_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/lfc_scan.sv -----
// ----------------------------------------------------------------------------
// lfc_scan
// Framing state machine, running CRC and result register. One beat is
// consumed per cycle whenever the result register can take a new entry.
// ----------------------------------------------------------------------------
module lfc_scan import lfc_pkg::*; #(
    parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_take,
    input  t_cfg       i_cfg,
    lfc_res_if.source  o_res
);

    t_phase                 r_phase,   n_phase;
    logic [LEN_W-1:0]       r_count,   n_count;
    logic [WORD_W-1:0]      r_len,     n_len;
    logic [WORD_W-1:0]      r_crc_ref, n_crc_ref;
    logic [WORD_W-1:0]      r_crc,     n_crc;
    logic [WORD_W-1:0]      r_mark,    n_mark;
    logic [OFFSET_BITS-1:0] r_offset,  n_offset;
    logic [WORD_W-1:0]      r_records, n_records;
    logic                   r_stopped, n_stopped;

    logic    r_out_valid;
    t_result r_out;

    logic             out_free;
    logic             step;
    logic             fire;
    logic             ev;
    logic [2:0]       cause;
    logic [LEN_W-1:0] rec_len;
    logic [31:0]      lane;
    logic [LEN_W-1:0] count_inc;

    assign out_free = !r_out_valid || o_res.ready;
    assign o_take   = out_free;
    assign step     = i_valid && out_free;

    // byte placed in its little-endian lane
    assign lane      = 32'(i_item.log_byte) << {r_count[1:0], 3'b000};
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_len     = r_len;
        n_crc_ref = r_crc_ref;
        n_crc     = r_crc;
        n_mark    = r_mark;
        n_offset  = r_offset;
        n_records = r_records;
        n_stopped = r_stopped;
        fire      = 1'b0;
        ev        = EV_STOP;
        cause     = CAUSE_NONE;
        rec_len   = '0;

        if (step) begin
            if (i_item.opcode == OP_END) begin
                if (!r_stopped) begin
                    fire  = 1'b1;
                    cause = (r_phase == PH_LEN && r_count == '0) ? CAUSE_CLEAN : CAUSE_TRUNC;
                end
                n_phase   = PH_LEN;
                n_count   = '0;
                n_len     = '0;
                n_crc_ref = '0;
                n_crc     = CRC_ONES;
                n_mark    = '0;
                n_offset  = '0;
                n_records = '0;
                n_stopped = 1'b0;
            end else if (!r_stopped) begin
                unique case (r_phase)
                    PH_LEN: begin
                        n_len   = r_len | lane;
                        n_count = count_inc;
                        if (r_count[1:0] == 2'd3) begin
                            n_phase = PH_CRC;
                            n_count = '0;
                        end
                    end
                    PH_CRC: begin
                        n_crc_ref = r_crc_ref | lane;
                        n_count   = count_inc;
                        if (r_count[1:0] == 2'd3) begin
                            n_count = '0;
                            if (r_len == '0 || r_len > WORD_W'(i_cfg.max_record_len)) begin
                                n_stopped = 1'b1;
                                fire      = 1'b1;
                                cause     = CAUSE_LENGTH;
                            end else begin
                                n_phase = PH_PAYLOAD;
                                n_crc   = CRC_ONES;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_crc   = crc_byte(r_crc, i_item.log_byte);
                        n_count = count_inc;
                        if (WORD_W'(count_inc) == r_len) begin
                            n_phase = PH_MARK;
                            n_count = '0;
                        end
                    end
                    PH_MARK: begin
                        n_mark  = r_mark | lane;
                        n_count = count_inc;
                        if (r_count[1:0] == 2'd3) begin
                            fire = 1'b1;
                            if (n_mark != i_cfg.end_mark) begin
                                n_stopped = 1'b1;
                                cause     = CAUSE_MARK;
                            end else if ((r_crc ^ CRC_ONES) != r_crc_ref) begin
                                n_stopped = 1'b1;
                                cause     = CAUSE_CRC;
                            end else begin
                                ev        = EV_RECORD;
                                rec_len   = r_len[LEN_W-1:0];
                                n_records = r_records + 1'b1;
                                n_offset  = r_offset + OFFSET_BITS'(r_len[LEN_W-1:0])
                                          + OFFSET_BITS'(HEADER_BYTES + MARK_BYTES);
                                n_phase   = PH_LEN;
                                n_count   = '0;
                                n_len     = '0;
                                n_crc_ref = '0;
                                n_crc     = CRC_ONES;
                                n_mark    = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_count   <= '0;
            r_len     <= '0;
            r_crc_ref <= '0;
            r_crc     <= CRC_ONES;
            r_mark    <= '0;
            r_offset  <= '0;
            r_records <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_len     <= n_len;
            r_crc_ref <= n_crc_ref;
            r_crc     <= n_crc;
            r_mark    <= n_mark;
            r_offset  <= n_offset;
            r_records <= n_records;
            r_stopped <= n_stopped;
        end
    end

    // result register; a stop reports the counters as they stood
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.event_res    <= ev;
            r_out.stop_cause   <= cause;
            r_out.record_len   <= rec_len;
            r_out.record_count <= (ev == EV_RECORD) ? n_records : r_records;
            r_out.intact_end   <= INTACT_W'((ev == EV_RECORD) ? n_offset : r_offset);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_out.event_res;
    assign o_res.stop_cause   = r_out.stop_cause;
    assign o_res.record_len   = r_out.record_len;
    assign o_res.record_count = r_out.record_count;
    assign o_res.intact_end   = r_out.intact_end;

endmodule

// ----- design/log_record_frame_checker_top.sv -----
// Log record frame checker. Scans a log one byte per beat and checks each
// record (length, CRC-32, payload, end mark). Bytes are taken at one per
// cycle while the result channel does not stall; a beat's result, if any, is
// presented on the result channel from the result register: the input register
// loads at the accepting edge and the framing step loads the result register
// when the scan stage takes the beat. Back-pressure on the result channel stalls
// input only while a result is held and not taken. Configuration writes take
// effect at the next edge and should be issued only while no beat is in flight.
// ----------------------------------------------------------------------------
// log_record_frame_checker_top
// Top level: configuration registers, input register and scan stage.
// ----------------------------------------------------------------------------
module log_record_frame_checker_top import lfc_pkg::*; #(
    parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfc_cfg_if.sink   i_cfg,
    lfc_item_if.sink  i_log,
    lfc_res_if.source o_res
);

    t_cfg  cfg;
    logic  in_valid;
    t_item in_item;
    logic  take;

    lfc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_log   (i_log),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    lfc_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_take  (take),
        .i_cfg   (cfg),
        .o_res   (o_res)
    );

endmodule

// ----- tb/log_record_frame_checker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_frame_checker_top_tb
// Drives byte logs through the frame checker under several limit and
// end-mark settings, predicts every result, and checks each result beat
// field by field, in order.
// ----------------------------------------------------------------------------
module log_record_frame_checker_top_tb;
    import lfc_pkg::*;

    localparam int unsigned OFFS_W     = OFFSET_BITS_DEF;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          SETTLE     = 8;

    typedef enum int {
        REC_GOOD,
        REC_BAD_MARK,
        REC_BAD_CRC,
        REC_BAD_BOTH,
        REC_ZERO_LEN,
        REC_OVERSIZE,
        REC_TRUNC
    } t_rec_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lfc_cfg_if  cfg_bus ();
    lfc_item_if log_bus ();
    lfc_res_if  res_bus ();

    log_record_frame_checker_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_log   (log_bus),
        .o_res   (res_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copies
    logic [LEN_W-1:0]  cfg_max;
    logic [WORD_W-1:0] cfg_mark;

    // scan state of the predictor
    t_phase            scan_phase;
    logic [LEN_W-1:0]  scan_cnt;
    logic [31:0]       hdr_len;
    logic [31:0]       hdr_crc;
    logic [31:0]       crc_acc;
    logic [31:0]       trailer;
    logic [OFFS_W-1:0] good_offset;
    logic [31:0]       good_records;
    bit                scan_halted;

    t_item   log_beats[$];
    t_result expected_results[$];
    int      beats_queued;
    int      mismatches;

    t_item   drv_beat = '0;
    bit      drv_loaded;
    bit      drv_calm;
    int      drv_gap;
    bit      mon_calm;
    int      mon_stall;
    t_result got_want;
    int      idle_cycles;

    function automatic logic [31:0] crc32_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic void restart_scan(input bit whole_log);
        scan_phase = PH_LEN;
        scan_cnt   = '0;
        hdr_len    = '0;
        hdr_crc    = '0;
        crc_acc    = CRC_ONES;
        trailer    = '0;
        if (whole_log) begin
            good_offset  = '0;
            good_records = '0;
            scan_halted  = 1'b0;
        end
    endfunction

    function automatic void expect_result(input logic ev, input logic [2:0] cause,
                                          input logic [LEN_W-1:0] len);
        t_result r;
        r.event_res    = ev;
        r.stop_cause   = cause;
        r.record_len   = len;
        r.record_count = good_records;
        r.intact_end   = INTACT_W'(good_offset);
        expected_results.push_back(r);
    endfunction

    function automatic void halt_scan(input logic [2:0] cause);
        scan_halted = 1'b1;
        expect_result(EV_STOP, cause, '0);
    endfunction

    // one accepted input beat through the predicted framing state
    function automatic void scan_beat(input t_item beat);
        logic [31:0] lane;
        lane = 32'(beat.log_byte) << (8 * scan_cnt[1:0]);
        if (beat.opcode == OP_END) begin
            if (!scan_halted) begin
                expect_result(EV_STOP, (scan_phase == PH_LEN && scan_cnt == 0) ?
                              CAUSE_CLEAN : CAUSE_TRUNC, '0);
            end
            restart_scan(1'b1);
            return;
        end
        if (scan_halted) begin
            return;
        end
        case (scan_phase)
            PH_LEN: begin
                hdr_len  = hdr_len | lane;
                scan_cnt = scan_cnt + 1'b1;
                if (scan_cnt == 4) begin
                    scan_phase = PH_CRC;
                    scan_cnt   = '0;
                end
            end
            PH_CRC: begin
                hdr_crc  = hdr_crc | lane;
                scan_cnt = scan_cnt + 1'b1;
                if (scan_cnt == 4) begin
                    scan_cnt = '0;
                    if (hdr_len == 0 || hdr_len > 32'(cfg_max)) begin
                        halt_scan(CAUSE_LENGTH);
                    end else begin
                        scan_phase = PH_PAYLOAD;
                        crc_acc    = CRC_ONES;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_acc  = crc32_step(crc_acc, beat.log_byte);
                scan_cnt = scan_cnt + 1'b1;
                if ({5'd0, scan_cnt} == hdr_len) begin
                    scan_phase = PH_MARK;
                    scan_cnt   = '0;
                end
            end
            default: begin
                trailer  = trailer | lane;
                scan_cnt = scan_cnt + 1'b1;
                if (scan_cnt == 4) begin
                    // mark is judged before the CRC
                    if (trailer != cfg_mark) begin
                        halt_scan(CAUSE_MARK);
                    end else if ((crc_acc ^ CRC_ONES) != hdr_crc) begin
                        halt_scan(CAUSE_CRC);
                    end else begin
                        good_records = good_records + 1;
                        good_offset  = good_offset + OFFS_W'(HEADER_BYTES) + OFFS_W'(hdr_len)
                                       + OFFS_W'(MARK_BYTES);
                        expect_result(EV_RECORD, CAUSE_NONE, hdr_len[LEN_W-1:0]);
                        restart_scan(1'b0);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void push_beat(input logic op, input logic [7:0] b);
        t_item it;
        it.opcode   = op;
        it.log_byte = b;
        log_beats.push_back(it);
        beats_queued++;
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            push_beat(OP_BYTE, w[8*i +: 8]);
        end
    endfunction

    function automatic void push_end();
        push_beat(OP_END, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_junk(input int n);
        for (int i = 0; i < n; i++) begin
            push_beat(OP_BYTE, 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void queue_record(input t_rec_kind kind);
        logic [31:0] len;
        logic [31:0] crc;
        logic [31:0] mark;
        logic [7:0]  pay[$];
        logic [7:0]  body[$];
        logic [7:0]  b;
        int          lim;
        int          cut;
        lim = (cfg_max > 8) ? 8 : int'(cfg_max);
        if (lim == 0) begin
            len = $urandom_range(1, 5);
        end else begin
            len = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, lim);
        end
        if (kind == REC_ZERO_LEN) begin
            len = '0;
        end else if (kind == REC_OVERSIZE) begin
            len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(cfg_max) + $urandom_range(1, 4);
        end
        crc = CRC_ONES;
        if (kind != REC_ZERO_LEN && kind != REC_OVERSIZE) begin
            for (int i = 0; i < int'(len); i++) begin
                b   = 8'($urandom_range(0, 255));
                crc = crc32_step(crc, b);
                pay.push_back(b);
            end
        end
        crc  = crc ^ CRC_ONES;
        mark = cfg_mark;
        if (kind == REC_BAD_CRC || kind == REC_BAD_BOTH) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        if (kind == REC_BAD_MARK || kind == REC_BAD_BOTH) begin
            mark = mark ^ (32'd1 << $urandom_range(0, 31));
        end
        for (int i = 0; i < 4; i++) body.push_back(len[8*i +: 8]);
        for (int i = 0; i < 4; i++) body.push_back(crc[8*i +: 8]);
        foreach (pay[i]) body.push_back(pay[i]);
        if (kind != REC_ZERO_LEN && kind != REC_OVERSIZE) begin
            for (int i = 0; i < 4; i++) body.push_back(mark[8*i +: 8]);
        end
        cut = (kind == REC_TRUNC) ? $urandom_range(1, body.size() - 1) : body.size();
        for (int i = 0; i < cut; i++) begin
            push_beat(OP_BYTE, body[i]);
        end
    endfunction

    // one log: mostly well-formed records, sometimes a fault or plain noise
    function automatic void queue_log();
        t_rec_kind kind;
        int        n_rec;
        int        pick;
        if ($urandom_range(0, 99) < 8) begin
            push_junk($urandom_range(3, 20));
            push_end();
            return;
        end
        n_rec = $urandom_range(1, 4);
        for (int r = 0; r < n_rec; r++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)      kind = REC_GOOD;
            else if (pick < 78) kind = REC_BAD_MARK;
            else if (pick < 84) kind = REC_BAD_CRC;
            else if (pick < 88) kind = REC_BAD_BOTH;
            else if (pick < 92) kind = REC_ZERO_LEN;
            else if (pick < 96) kind = REC_OVERSIZE;
            else                kind = REC_TRUNC;
            queue_record(kind);
            if (kind != REC_GOOD) begin
                if (kind != REC_TRUNC) begin
                    push_junk($urandom_range(0, 3));
                end
                break;
            end
        end
        push_end();
    endfunction

    function automatic void queue_logs(input int n_beats);
        int target;
        target = beats_queued + n_beats;
        while (beats_queued < target) begin
            queue_log();
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (idx == CFG_MAX_RECORD_LEN) begin
            cfg_max = val[LEN_W-1:0];
        end else begin
            cfg_mark = val;
        end
    endtask

    // wait for the sender to empty and every predicted result to arrive
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (log_beats.size() != 0 || drv_loaded || expected_results.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // ---------------- sender ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            log_bus.valid <= 1'b0;
            drv_loaded = 1'b0;
            drv_gap    = 0;
        end else begin
            if (log_bus.valid && log_bus.ready) begin
                scan_beat(drv_beat);
                drv_loaded = 1'b0;
                if ($urandom_range(0, 29) == 0) begin
                    drv_calm = !drv_calm;
                end
                drv_gap = drv_calm ? 0 : $urandom_range(0, 6);
            end else if (!drv_loaded && drv_gap > 0) begin
                drv_gap--;
            end
            if (!drv_loaded && drv_gap == 0 && log_beats.size() > 0) begin
                drv_beat   = log_beats.pop_front();
                drv_loaded = 1'b1;
            end
            log_bus.valid    <= drv_loaded;
            log_bus.opcode   <= drv_beat.opcode;
            log_bus.log_byte <= drv_beat.log_byte;
        end
    end

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            mon_stall = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with none expected: event_res %0d stop_cause %0d",
                           res_bus.event_res, res_bus.stop_cause);
                    mismatches++;
                end else begin
                    got_want = expected_results.pop_front();
                    check_field("event_res", got_want.event_res, res_bus.event_res);
                    check_field("stop_cause", got_want.stop_cause, res_bus.stop_cause);
                    check_field("record_len", got_want.record_len, res_bus.record_len);
                    check_field("record_count", got_want.record_count, res_bus.record_count);
                    check_field("intact_end", got_want.intact_end, res_bus.intact_end);
                end
                if ($urandom_range(0, 29) == 0) begin
                    mon_calm = !mon_calm;
                end
                mon_stall = mon_calm ? 0 : $urandom_range(0, 6);
            end else if (mon_stall > 0) begin
                mon_stall--;
            end
            res_bus.ready <= (mon_stall == 0);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (log_bus.valid && log_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no beat moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_MAX_RECORD_LEN;
        cfg_bus.data     = '0;
        log_bus.valid    = 1'b0;
        log_bus.opcode   = OP_BYTE;
        log_bus.log_byte = '0;
        res_bus.ready    = 1'b0;
        idle_cycles      = 0;
        cfg_max          = LIMIT_RESET;
        cfg_mark         = '0;
        restart_scan(1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: one-byte record, clean end, zero length,
        // bytes and end after a stop, truncated log
        push_word(32'd1);
        push_word(crc32_step(CRC_ONES, 8'hFF) ^ CRC_ONES);
        push_beat(OP_BYTE, 8'hFF);
        push_word(32'd0);
        push_end();
        push_word(32'd0);
        push_word($urandom);
        push_beat(OP_BYTE, 8'h00);
        push_end();
        push_beat(OP_BYTE, 8'h5A);
        push_end();
        drain();

        // smallest nonzero limit, all-ones mark
        write_reg(CFG_MAX_RECORD_LEN, 32'd1);
        write_reg(CFG_END_MARK, 32'hFFFF_FFFF);
        queue_logs(80);
        drain();

        // zero limit: every header stops the scan
        write_reg(CFG_MAX_RECORD_LEN, 32'd0);
        write_reg(CFG_END_MARK, 32'd0);
        queue_logs(25);
        drain();

        // largest limit
        write_reg(CFG_MAX_RECORD_LEN, 32'(LEN_W'('1)));
        write_reg(CFG_END_MARK, $urandom);
        queue_logs(80);
        drain();

        // small limit; sender pauses until all results are in
        write_reg(CFG_MAX_RECORD_LEN, 32'd6);
        write_reg(CFG_END_MARK, $urandom);
        queue_logs(45);
        drain();
        queue_logs(45);
        drain();

        write_reg(CFG_MAX_RECORD_LEN, 32'(LIMIT_RESET));
        write_reg(CFG_END_MARK, $urandom);
        queue_logs(25);
        drain();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/lfc_pkg.sv
design/lfc_if.sv
design/lfc_cfg_regs.sv
design/lfc_in_stage.sv
design/lfc_scan.sv
design/log_record_frame_checker_top.sv
tb/log_record_frame_checker_top_tb.sv
